// ----- sv/framed_command_receiver_core_assert.svh -----
// Assertion macros shared by the framed command receiver modules.
`ifndef FRAMED_COMMAND_RECEIVER_CORE_ASSERT_SVH
`define FRAMED_COMMAND_RECEIVER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FCR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcr assertion failed");

// Check that cons holds in the cycle after ante.
`define FCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcr assertion failed");

`endif

// ----- sv/fcr_pkg.sv -----
// Constants and types of the framed command receiver.
package fcr_pkg;

    localparam int BUF_DEPTH_DEF = 32;
    localparam int KEPT_BYTES    = 3;

    localparam logic [7:0] CH_START = 8'h3C;  // '<'
    localparam logic [7:0] CH_END   = 8'h3E;  // '>'
    localparam logic [7:0] CMD_INFO = 8'h49;  // 'I'
    localparam logic [7:0] CMD_FIRE = 8'h46;  // 'F'
    localparam logic [7:0] SEL_ARM  = 8'h41;  // 'A'
    localparam logic [7:0] SEL_FIRE = 8'h46;  // 'F'
    localparam logic [7:0] VAL_EN   = 8'h45;  // 'E'
    localparam logic [7:0] VAL_DIS  = 8'h44;  // 'D'

    // Position of a byte within the five-byte status reply.
    typedef logic [2:0] reply_pos_t;
    localparam reply_pos_t POS_START = 3'd0;
    localparam reply_pos_t POS_CMD   = 3'd1;
    localparam reply_pos_t POS_ARM   = 3'd2;
    localparam reply_pos_t POS_FIRE  = 3'd3;
    localparam reply_pos_t POS_END   = 3'd4;

    // Pending status reply handed from the frame parser to the serializer.
    typedef struct packed {
        logic valid;
        logic arm;
        logic fire;
    } reply_req_t;

endpackage

// ----- sv/fcr_if.sv -----
// Channel interfaces of the framed command receiver.
interface byte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface reply_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       arm_level;
    logic       fire_level;

    modport source (output valid, output tx_byte, output last_byte,
                    output arm_level, output fire_level, input ready);
    modport sink (input valid, input tx_byte, input last_byte,
                  input arm_level, input fire_level, output ready);
endinterface

// ----- sv/fcr_frame.sv -----
// Frame parser: collects command bytes, updates the output levels, queues replies.
`include "framed_command_receiver_core_assert.svh"

module fcr_frame #(
    parameter int BUF_DEPTH = fcr_pkg::BUF_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    byte_in_if.sink             rx,
    input  logic                take,
    output fcr_pkg::reply_req_t req
);
    import fcr_pkg::*;

    localparam int IdxW = $clog2(BUF_DEPTH);

    logic [7:0]      frame_reg  [KEPT_BYTES];
    logic [7:0]      frame_next [KEPT_BYTES];
    logic [IdxW-1:0] widx_reg;
    logic [IdxW-1:0] widx_next;
    logic            arm_reg;
    logic            arm_next;
    logic            fire_reg;
    logic            fire_next;
    reply_req_t      req_reg;
    reply_req_t      req_next;
    logic            accept;
    logic            new_req;

    // Take a byte whenever the reply slot is free or drains this cycle.
    assign rx.ready = !req_reg.valid || take;
    assign accept   = rx.valid && rx.ready;
    assign req      = req_reg;

    always_comb
    begin
        frame_next = frame_reg;
        widx_next  = widx_reg;
        arm_next   = arm_reg;
        fire_next  = fire_reg;
        new_req    = 1'b0;
        if (accept)
        begin
            if (rx.rx_byte == CH_START)
            begin
                widx_next = '0;
            end
            else if (rx.rx_byte != CH_END)
            begin
                // Only the first three positions matter; higher ones just advance.
                if (widx_reg < IdxW'(KEPT_BYTES))
                begin
                    frame_next[widx_reg[1:0]] = rx.rx_byte;
                end
                widx_next = (widx_reg == IdxW'(BUF_DEPTH - 1)) ? '0 : widx_reg + 1'b1;
            end
            else if (frame_reg[0] == CMD_INFO)
            begin
                new_req = 1'b1;
            end
            else if (frame_reg[0] == CMD_FIRE)
            begin
                new_req = 1'b1;
                if (frame_reg[1] == SEL_ARM)
                begin
                    if (frame_reg[2] == VAL_EN)
                        arm_next = 1'b1;
                    else if (frame_reg[2] == VAL_DIS)
                        arm_next = 1'b0;
                end
                else if (frame_reg[1] == SEL_FIRE)
                begin
                    if (frame_reg[2] == VAL_EN)
                        fire_next = 1'b1;
                    else if (frame_reg[2] == VAL_DIS)
                        fire_next = 1'b0;
                end
            end
        end

        req_next.valid = (req_reg.valid && !take) || new_req;
        req_next.arm   = new_req ? arm_next  : req_reg.arm;
        req_next.fire  = new_req ? fire_next : req_reg.fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEPT_BYTES; i++)
            begin
                frame_reg[i] <= '0;
            end
            widx_reg <= '0;
            arm_reg  <= 1'b0;
            fire_reg <= 1'b0;
            req_reg  <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
            widx_reg  <= widx_next;
            arm_reg   <= arm_next;
            fire_reg  <= fire_next;
            req_reg   <= req_next;
        end
    end

    `FCR_ASSERT_NEXT(a_start_clears_index, accept && rx.rx_byte == CH_START, widx_reg == '0)
    `FCR_ASSERT_NEXT(a_pending_req_holds, req_reg.valid && !take,
                     req_reg.valid && $stable(req_reg.arm) && $stable(req_reg.fire))
    `FCR_ASSERT_NOW(a_take_needs_req, take, req_reg.valid)

endmodule

// ----- sv/fcr_reply.sv -----
// Reply serializer: sends the five-byte status reply one byte per transaction.
`include "framed_command_receiver_core_assert.svh"

module fcr_reply (
    input  logic                clk,
    input  logic                rst_n,
    input  fcr_pkg::reply_req_t req,
    output logic                take,
    reply_out_if.source         tx
);
    import fcr_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    reply_pos_t pos_reg;
    reply_pos_t pos_next;
    logic       arm_reg;
    logic       arm_next;
    logic       fire_reg;
    logic       fire_next;
    logic       out_hs;
    logic       at_end;

    assign at_end = (pos_reg == POS_END);
    assign out_hs = tx.valid && tx.ready;
    // Load the next reply when idle or when the closing byte leaves.
    assign take   = req.valid && (!busy_reg || (out_hs && at_end));

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        arm_next  = arm_reg;
        fire_next = fire_reg;
        if (take)
        begin
            busy_next = 1'b1;
            pos_next  = POS_START;
            arm_next  = req.arm;
            fire_next = req.fire;
        end
        else if (out_hs)
        begin
            if (at_end)
                busy_next = 1'b0;
            else
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_START;
            arm_reg  <= 1'b0;
            fire_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            arm_reg  <= arm_next;
            fire_reg <= fire_next;
        end
    end

    always_comb
    begin
        unique case (pos_reg)
            POS_START: tx.tx_byte = CH_START;
            POS_CMD:   tx.tx_byte = CMD_FIRE;
            POS_ARM:   tx.tx_byte = arm_reg  ? VAL_EN : VAL_DIS;
            POS_FIRE:  tx.tx_byte = fire_reg ? VAL_EN : VAL_DIS;
            default:   tx.tx_byte = CH_END;
        endcase
    end

    assign tx.valid      = busy_reg;
    assign tx.last_byte  = at_end;
    assign tx.arm_level  = arm_reg;
    assign tx.fire_level = fire_reg;

    `FCR_ASSERT_NEXT(a_burst_continues, out_hs && !at_end, busy_reg)
    `FCR_ASSERT_NEXT(a_stall_holds_byte, busy_reg && !tx.ready,
                     busy_reg && $stable(pos_reg) && $stable(arm_reg) && $stable(fire_reg))
    `FCR_ASSERT_NOW(a_pos_in_range, busy_reg, pos_reg <= POS_END)

endmodule

// ----- sv/framed_command_receiver_core.sv -----
// Framed command receiver: byte stream in, status reply bytes out.
//
// rx carries one received serial byte per transaction. A '<' restarts the
// frame, other bytes except '>' fill its first three positions, and a '>' acts on it.
// An 'I' frame, or an 'F' frame after updating the arm or fire level, queues
// the reply "<F a f>" on tx: five transactions, last_byte set on the '>'.
// Every tx transaction also carries the arm and fire levels of its reply.
// A '>' fills the reply slot; the serializer then loads the slot and offers the reply.
// Throughput: one rx byte per cycle while rx.ready is high; tx sends one byte per
// cycle while tx.ready is high. One reply can wait while another is being sent;
// while it waits, rx.ready drops until the serializer takes it, which happens
// when the closing byte of the current reply leaves the tx port.
// A tx stall holds the current reply byte and, once the slot fills, stalls rx.
// Reset clears the stored frame bytes, the write index and both levels, and
// drops any reply in flight; rx is ready as soon as reset is released.
module framed_command_receiver_core #(
    parameter int BUF_DEPTH = fcr_pkg::BUF_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    byte_in_if.sink     rx,
    reply_out_if.source tx
);
    import fcr_pkg::*;

    reply_req_t req;
    logic       take;

    fcr_frame #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_frame (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .req   (req)
    );

    fcr_reply u_reply (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .tx    (tx)
    );

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the framed command receiver: byte stream in, status replies checked.
`timescale 1ns / 1ps

module tb;
    import fcr_pkg::*;

    localparam int RX_BUF_DEPTH = BUF_DEPTH_DEF;
    localparam int RANDOM_END   = 430;
    localparam int QUIET_FROM   = 350;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       arm_level;
        logic       fire_level;
    } reply_beat_t;

    // Tracks the frame parser and the arm/fire levels, and holds the reply bytes still due.
    class reply_scoreboard;
        logic [7:0]  frame_bytes [KEPT_BYTES];
        int unsigned write_index;
        logic        arm_on;
        logic        fire_on;
        reply_beat_t expected_replies [$];
        int unsigned error_count;

        function new();
            foreach (frame_bytes[i])
            begin
                frame_bytes[i] = 8'h00;
            end
            write_index = 0;
            arm_on      = 1'b0;
            fire_on     = 1'b0;
            error_count = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_error(string msg);
            error_count++;
            if (error_count <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        function logic apply_level(logic cur, logic [7:0] v);
            if (v == VAL_EN)
            begin
                return 1'b1;
            end
            if (v == VAL_DIS)
            begin
                return 1'b0;
            end
            return cur;
        endfunction

        function void queue_status_reply();
            logic [7:0] arm_char;
            logic [7:0] fire_char;
            arm_char  = arm_on ? VAL_EN : VAL_DIS;
            fire_char = fire_on ? VAL_EN : VAL_DIS;
            expected_replies.push_back('{CH_START, 1'b0, arm_on, fire_on});
            expected_replies.push_back('{CMD_FIRE, 1'b0, arm_on, fire_on});
            expected_replies.push_back('{arm_char, 1'b0, arm_on, fire_on});
            expected_replies.push_back('{fire_char, 1'b0, arm_on, fire_on});
            expected_replies.push_back('{CH_END, 1'b1, arm_on, fire_on});
        endfunction

        // Note one accepted rx transaction.
        function void take_rx_byte(logic [7:0] b);
            if (b == CH_START)
            begin
                write_index = 0;
            end
            else if (b != CH_END)
            begin
                if (write_index < KEPT_BYTES)
                begin
                    frame_bytes[write_index] = b;
                end
                write_index = (write_index + 1) % RX_BUF_DEPTH;
            end
            else if (frame_bytes[0] == CMD_INFO)
            begin
                queue_status_reply();
            end
            else if (frame_bytes[0] == CMD_FIRE)
            begin
                if (frame_bytes[1] == SEL_ARM)
                begin
                    arm_on = apply_level(arm_on, frame_bytes[2]);
                end
                else if (frame_bytes[1] == SEL_FIRE)
                begin
                    fire_on = apply_level(fire_on, frame_bytes[2]);
                end
                queue_status_reply();
            end
        endfunction

        // Check one accepted tx transaction against the oldest reply byte due.
        function void check_tx_byte(reply_beat_t got);
            reply_beat_t want;
            if (expected_replies.size() == 0)
            begin
                note_error($sformatf("unexpected tx byte %02h last %0b arm %0b fire %0b",
                                     got.tx_byte, got.last_byte, got.arm_level,
                                     got.fire_level));
                return;
            end
            want = expected_replies.pop_front();
            if (got.tx_byte !== want.tx_byte || got.last_byte !== want.last_byte ||
                got.arm_level !== want.arm_level || got.fire_level !== want.fire_level)
            begin
                note_error($sformatf({"tx byte: expected %02h/%0b/%0b/%0b,",
                                      " got %02h/%0b/%0b/%0b (byte/last/arm/fire)"},
                                     want.tx_byte, want.last_byte, want.arm_level,
                                     want.fire_level, got.tx_byte, got.last_byte,
                                     got.arm_level, got.fire_level));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    bit          allow_idle = 1'b1;
    int unsigned rx_count = 0;
    int unsigned cycle_count = 0;

    reply_scoreboard sb = new();

    byte_in_if   rx_ch ();
    reply_out_if tx_ch ();

    framed_command_receiver_core #(
        .BUF_DEPTH (RX_BUF_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch.sink),
        .tx    (tx_ch.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            sb.check_tx_byte('{tx_ch.tx_byte, tx_ch.last_byte, tx_ch.arm_level,
                               tx_ch.fire_level});
        end
    end

    // Stall tx in random bursts.
    initial
    begin
        tx_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (allow_idle && $urandom_range(0, 5) == 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            tx_ch.ready <= 1'b1;
        end
    end

    // Call at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        sb.take_rx_byte(b);
        rx_count++;
        @(negedge clk);
    endtask

    task automatic send_fire_frame(input logic [7:0] sel, input logic [7:0] val);
        send_byte(CH_START);
        send_byte(CMD_FIRE);
        send_byte(sel);
        send_byte(val);
        send_byte(CH_END);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_START || b == CH_END);
        return b;
    endfunction

    function automatic logic [7:0] pick_sel();
        case ($urandom_range(0, 4))
            0, 1:    return SEL_ARM;
            2, 3:    return SEL_FIRE;
            default: return plain_byte();
        endcase
    endfunction

    function automatic logic [7:0] pick_val();
        case ($urandom_range(0, 4))
            0, 1:    return VAL_EN;
            2, 3:    return VAL_DIS;
            default: return plain_byte();
        endcase
    endfunction

    initial
    begin
        int unsigned kind;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // End mark on the all-zero frame: no reply.
        send_byte(CH_END);
        // Command stored before any start mark.
        send_byte(CMD_INFO);
        send_byte(CH_END);
        send_fire_frame(SEL_ARM, VAL_EN);
        send_fire_frame(SEL_FIRE, VAL_EN);
        send_fire_frame(SEL_ARM, 8'hFF);
        send_fire_frame(8'h00, VAL_DIS);
        send_fire_frame(SEL_ARM, VAL_DIS);
        // Repeat the stale frame.
        send_byte(CH_END);

        while (rx_count < RANDOM_END)
        begin
            if (rx_count >= QUIET_FROM)
            begin
                allow_idle = 1'b0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_byte(CH_START);
                    send_byte($urandom_range(0, 3) == 0 ? plain_byte() : CMD_INFO);
                    repeat ($urandom_range(0, 3)) send_byte(plain_byte());
                    send_byte(CH_END);
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    // Short frame: byte 2 left over from before.
                    send_byte(CH_START);
                    send_byte(CMD_FIRE);
                    send_byte(pick_sel());
                    send_byte(CH_END);
                end
                else
                begin
                    send_fire_frame(pick_sel(), pick_val());
                end
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (kind < 82)
            begin
                // Long frame that may wrap the write index onto the command.
                send_byte(CH_START);
                repeat ($urandom_range(29, 34)) send_byte(plain_byte());
                send_byte(CMD_FIRE);
                send_byte(pick_sel());
                send_byte(pick_val());
                send_byte(CH_END);
            end
            else if (kind < 91)
            begin
                send_byte(CH_END);
            end
            else
            begin
                // Abandoned frame, restarted by the next start mark.
                send_byte(CH_START);
                repeat ($urandom_range(1, 2)) send_byte(plain_byte());
            end
        end
        rx_ch.valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/fcr_pkg.sv
sv/fcr_if.sv
sv/fcr_frame.sv
sv/fcr_reply.sv
sv/framed_command_receiver_core.sv
tb/sv/tb.sv
